// File: hw/rtl/krte_pkg.sv
package krte_pkg;

    // Item kinds on the input stream
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TIMER  = 1'b1;

    // One stored list entry
    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] record;
        logic [7:0]  id;
    } krte_entry_t;

    // Removal rule applied by the shared evaluation unit during a scan pass
    typedef enum logic [1:0] {
        OP_MATCH,
        OP_DROP_HEAD,
        OP_EXPIRE
    } krte_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_APPEND,
        ST_EMIT_RD,
        ST_EMIT_LD
    } krte_state_t;

    // Request to the evaluation unit for one candidate entry
    typedef struct packed {
        krte_op_t    op;
        logic [7:0]  cand_id;
        logic [31:0] cand_stamp;
        logic [7:0]  item_id;
        logic [31:0] now;
        logic [15:0] expiry;
        logic        matched;
        logic        is_head;
    } krte_eval_t;

endpackage

// File: hw/rtl/krte_mem.sv
module krte_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  krte_pkg::krte_entry_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output krte_pkg::krte_entry_t rdata
);
    import krte_pkg::*;

    krte_entry_t mem_array [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_array[raddr];
        end
    end

endmodule

// File: hw/rtl/krte_alu.sv
module krte_alu (
    input  krte_pkg::krte_eval_t req,
    output logic                 drop
);
    import krte_pkg::*;

    logic [31:0] age;

    // Age wraps modulo 2^32
    assign age = req.now - req.cand_stamp;

    always_comb
    begin
        case (req.op)
            OP_MATCH:     drop = (req.cand_id == req.item_id) && !req.matched;
            OP_DROP_HEAD: drop = req.is_head;
            OP_EXPIRE:    drop = age > {16'd0, req.expiry};
            default:      drop = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/keyed_record_table_with_expiry_unit.sv
// Keyed record table with expiry. The block holds an ordered list of up to
// TABLE_DEPTH records (oldest first), one per object id, in a single-port-write,
// registered-read memory. A report beat (tuser = 0) removes any entry with the
// same id, appends the new record and then streams the whole list, one beat per
// entry, tlast on the final one; when the table was full and the id was new, the
// oldest entry is dropped and every beat of that list carries tuser[1] = 1.
// A timer beat (tuser = 1) removes every entry whose age (now minus stamp,
// modulo 2^32 ms) exceeds expiry_ms and streams the list only if something was
// removed; an emptied list streams as one beat with tuser[0] = 0 and tlast = 1.
// Flow: one item at a time, s_axis_tready is high only while idle. Each
// entry in a scan pass is read from memory, then evaluated and compacted
// through one shared compare/subtract unit; each emitted beat is read from
// memory, then loaded into the output register, which holds while the sink
// stalls. On N stored entries a report streams N + 1 beats for a new id, N
// for a known id or a full table; a full table that gets a new id first runs
// a second scan pass that drops its oldest entry. A timer that removes entries
// streams the survivors, or the empty-list beat. The last beat may wait in the
// output register while the next item is taken. The user must write expiry_ms
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce
// this. expiry_ms resets to 1000.
module keyed_record_table_with_expiry_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // expiry_ms
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [7:0] object_id, [39:8] record_value,
                                       // [71:40] time_value
    input  logic        s_axis_tuser,  // [0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [7:0] entry_id, [39:8] entry_record,
                                       // [71:40] entry_time
    output logic        m_axis_tlast,  // last_entry
    output logic [1:0]  m_axis_tuser   // [0] entry_valid, [1] dropped_oldest
);
    import krte_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    krte_state_t state_reg, state_next;

    logic [15:0]   expiry_reg, expiry_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic          removed_reg, removed_next;
    logic          matched_reg, matched_next;
    logic          dropped_reg, dropped_next;
    krte_op_t      op_reg, op_next;

    // latched item
    logic [7:0]    item_id_reg, item_id_next;
    logic [31:0]   item_rec_reg, item_rec_next;
    logic [31:0]   item_now_reg, item_now_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    krte_entry_t   out_entry_reg, out_entry_next;
    logic          out_last_reg, out_last_next;
    logic          out_evalid_reg, out_evalid_next;
    logic          out_drop_reg, out_drop_next;

    // memory port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    krte_entry_t   mem_wdata, mem_rdata;

    krte_eval_t    eval_req;
    logic          drop;

    logic [CW-1:0] keep_after;
    logic [CW-1:0] scan_inc;
    logic          scan_last;
    logic          restart_head;
    logic          removed_after;
    logic          emit_empty;
    logic          emit_last;
    logic          out_free;
    logic          in_accept;

    krte_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared evaluation unit: id compare, head test or wrapped age compare
    assign eval_req.op         = op_reg;
    assign eval_req.cand_id    = mem_rdata.id;
    assign eval_req.cand_stamp = mem_rdata.stamp;
    assign eval_req.item_id    = item_id_reg;
    assign eval_req.now        = item_now_reg;
    assign eval_req.expiry     = expiry_reg;
    assign eval_req.matched    = matched_reg;
    assign eval_req.is_head    = (scan_idx_reg == '0);

    krte_alu u_alu (
        .req  (eval_req),
        .drop (drop)
    );

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign keep_after    = drop ? keep_reg : keep_reg + CW'(1);
    assign scan_inc      = scan_idx_reg + CW'(1);
    assign scan_last     = (scan_inc == count_reg);
    assign removed_after = removed_reg | drop;
    // A new id found a full table: run a second pass that drops the head
    assign restart_head  = (op_reg == OP_MATCH) && (keep_after == FULL_COUNT);
    assign emit_empty    = (count_reg == '0);
    assign emit_last     = emit_empty || scan_last;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (count_reg != '0)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (s_axis_tuser == KIND_REPORT)
                    begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (!scan_last)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    case (op_reg)
                        OP_MATCH:
                        begin
                            state_next = restart_head ? ST_SCAN_RD : ST_APPEND;
                        end
                        OP_DROP_HEAD:
                        begin
                            state_next = ST_APPEND;
                        end
                        OP_EXPIRE:
                        begin
                            if (!removed_after)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (keep_after == '0)
                            begin
                                state_next = ST_EMIT_LD;
                            end
                            else
                            begin
                                state_next = ST_EMIT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_APPEND:
            begin
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates
    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE);
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = keep_reg[AW-1:0];
        mem_raddr       = scan_idx_reg[AW-1:0];
        mem_wdata       = mem_rdata;

        expiry_next     = cfg_we ? cfg_wdata : expiry_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        keep_next       = keep_reg;
        removed_next    = removed_reg;
        matched_next    = matched_reg;
        dropped_next    = dropped_reg;
        op_next         = op_reg;
        item_id_next    = item_id_reg;
        item_rec_next   = item_rec_reg;
        item_now_next   = item_now_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        out_evalid_next = out_evalid_reg;
        out_drop_next   = out_drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_id_next  = s_axis_tdata[7:0];
                    item_rec_next = s_axis_tdata[39:8];
                    item_now_next = s_axis_tdata[71:40];
                    scan_idx_next = '0;
                    keep_next     = '0;
                    removed_next  = 1'b0;
                    matched_next  = 1'b0;
                    dropped_next  = 1'b0;
                    op_next       = (s_axis_tuser == KIND_TIMER) ? OP_EXPIRE : OP_MATCH;
                end
            end
            ST_SCAN_RD:
            begin
                mem_re = 1'b1;
            end
            ST_SCAN_EV:
            begin
                // Compact: kept entries move down to the keep index
                mem_we        = !drop;
                matched_next  = matched_reg | drop;
                removed_next  = removed_after;
                keep_next     = keep_after;
                scan_idx_next = scan_inc;
                if (scan_last)
                begin
                    count_next    = keep_after;
                    scan_idx_next = '0;
                    keep_next     = '0;
                    if (restart_head)
                    begin
                        op_next      = OP_DROP_HEAD;
                        dropped_next = 1'b1;
                    end
                end
            end
            ST_APPEND:
            begin
                mem_we          = 1'b1;
                mem_waddr       = count_reg[AW-1:0];
                mem_wdata.id     = item_id_reg;
                mem_wdata.record = item_rec_reg;
                mem_wdata.stamp  = item_now_reg;
                count_next      = count_reg + CW'(1);
                scan_idx_next   = '0;
            end
            ST_EMIT_RD:
            begin
                mem_re = 1'b1;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = emit_empty ? '0 : mem_rdata;
                    out_last_next   = emit_last;
                    out_evalid_next = !emit_empty;
                    out_drop_next   = dropped_reg && !emit_empty;
                    scan_idx_next   = scan_inc;
                end
            end
            default:
            begin
                scan_idx_next = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expiry_reg    <= 16'd1000;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            keep_reg      <= '0;
            removed_reg   <= 1'b0;
            matched_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            op_reg        <= OP_MATCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expiry_reg    <= expiry_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            keep_reg      <= keep_next;
            removed_reg   <= removed_next;
            matched_reg   <= matched_next;
            dropped_reg   <= dropped_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_id_reg    <= item_id_next;
        item_rec_reg   <= item_rec_next;
        item_now_reg   <= item_now_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
        out_evalid_reg <= out_evalid_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_entry_reg.stamp, out_entry_reg.record, out_entry_reg.id};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_drop_reg, out_evalid_reg};

`ifndef SYNTHESIS
    // The list never grows past the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds table depth");

    // Compaction never writes ahead of the entry being read
    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_EV) |-> (keep_reg <= scan_idx_reg))
        else $error("compaction write index ahead of scan index");

    // Append always finds a free slot
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPEND) |-> (count_reg < FULL_COUNT))
        else $error("append into a full table");

    // The empty-list beat is always the only and last beat
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && !m_axis_tuser[1]))
        else $error("empty-list beat without tlast or with drop flag");
`endif

endmodule

// File: sim/krte_list_checker.sv
module krte_list_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser,
    output int          mismatch_count,
    output int          beats_pending
);
    import krte_pkg::*;

    typedef struct packed {
        logic        valid;
        logic [7:0]  id;
        logic [31:0] record;
        logic [31:0] stamp;
        logic        last;
        logic        dropped;
    } list_beat_t;

    krte_entry_t stored_list[$];
    list_beat_t  list_beats_due[$];
    logic [15:0] expiry_limit = 16'd1000;
    int          error_total = 0;

    // Queue one beat per stored entry, or a single invalid beat for an empty list
    function automatic void queue_list_beats(input logic dropped);
        list_beat_t b;
        if (stored_list.size() == 0) begin
            b = '0;
            b.last = 1'b1;
            list_beats_due.insert(list_beats_due.size(), b);
        end
        else begin
            for (int i = 0; i < stored_list.size(); i++) begin
                b.valid   = 1'b1;
                b.id      = stored_list[i].id;
                b.record  = stored_list[i].record;
                b.stamp   = stored_list[i].stamp;
                b.last    = (i == stored_list.size() - 1);
                b.dropped = dropped;
                list_beats_due.insert(list_beats_due.size(), b);
            end
        end
    endfunction

    function automatic void apply_report(input logic [7:0] id, input logic [31:0] rec,
                                         input logic [31:0] stamp);
        krte_entry_t e;
        logic        dropped;
        dropped = 1'b0;
        for (int i = 0; i < stored_list.size(); i++) begin
            if (stored_list[i].id == id) begin
                stored_list.delete(i);
                break;
            end
        end
        if (stored_list.size() >= TABLE_DEPTH) begin
            stored_list.delete(0);
            dropped = 1'b1;
        end
        e.id     = id;
        e.record = rec;
        e.stamp  = stamp;
        stored_list.insert(stored_list.size(), e);
        queue_list_beats(dropped);
    endfunction

    // Age wraps modulo 2^32, so a stamp ahead of now reads as very old
    function automatic void apply_timer(input logic [31:0] now);
        krte_entry_t survivors[$];
        logic        removed;
        logic [31:0] age;
        removed = 1'b0;
        foreach (stored_list[i]) begin
            age = now - stored_list[i].stamp;
            if (age > {16'd0, expiry_limit})
                removed = 1'b1;
            else
                survivors.insert(survivors.size(), stored_list[i]);
        end
        stored_list = survivors;
        if (removed)
            queue_list_beats(1'b0);
    endfunction

    function automatic void check_list_beat(input list_beat_t got);
        list_beat_t want;
        if (list_beats_due.size() == 0) begin
            error_total++;
            if (error_total <= 10)
                $display("unexpected list beat: valid=%0b id=%02h rec=%08h ",
                         got.valid, got.id, got.record,
                         "time=%08h last=%0b drop=%0b",
                         got.stamp, got.last, got.dropped);
        end
        else begin
            want = list_beats_due.pop_front();
            if (got !== want) begin
                error_total++;
                if (error_total <= 10) begin
                    $display("list beat mismatch: expected valid=%0b id=%02h rec=%08h ",
                             want.valid, want.id, want.record,
                             "time=%08h last=%0b drop=%0b",
                             want.stamp, want.last, want.dropped);
                    $display("                    actual   valid=%0b id=%02h rec=%08h ",
                             got.valid, got.id, got.record,
                             "time=%08h last=%0b drop=%0b",
                             got.stamp, got.last, got.dropped);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stored_list.delete();
            list_beats_due.delete();
            expiry_limit = 16'd1000;
            mismatch_count <= error_total;
            beats_pending  <= 0;
        end
        else begin
            // Retire output first: a beat leaving now belongs to an earlier item
            if (m_axis_tvalid && m_axis_tready)
                check_list_beat({m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[39:8],
                                 m_axis_tdata[71:40], m_axis_tlast, m_axis_tuser[1]});
            if (cfg_we)
                expiry_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == KIND_REPORT)
                    apply_report(s_axis_tdata[7:0], s_axis_tdata[39:8], s_axis_tdata[71:40]);
                else
                    apply_timer(s_axis_tdata[71:40]);
            end
            mismatch_count <= error_total;
            beats_pending  <= list_beats_due.size();
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    import krte_pkg::*;

    localparam int DEPTH         = 64;
    // Longest correct quiet stretch is a full-table report
    // plus a long sender gap and a long sink stall; allow many times that.
    localparam int STALL_LIMIT   = 6000;
    // A timer that removes nothing emits no beat but still scans the whole list
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEM_TARGET   = 480;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;     // expiry_ms
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;     // [7:0] object_id, [39:8] record_value,
                                        // [71:40] time_value
    logic        s_axis_tuser = 1'b0;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [7:0] entry_id, [39:8] entry_record,
                                        // [71:40] entry_time
    logic        m_axis_tlast;          // last_entry
    logic [1:0]  m_axis_tuser;          // [0] entry_valid, [1] dropped_oldest

    int          mismatch_count;
    int          beats_pending;

    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          cur_expiry = 1000;
    logic [31:0] clock_ms = 32'd0;
    bit          tx_steady = 1'b0;      // sender adds no random gaps while set
    bit          rx_choppy = 1'b1;      // sink stalls at random while set
    int          rx_stall = 0;
    int          rx_roll;

    keyed_record_table_with_expiry_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    krte_list_checker #(
        .TABLE_DEPTH(DEPTH)
    ) list_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatch_count(mismatch_count),
        .beats_pending (beats_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sink side: either always ready, or mostly short stalls with a few long ones
    always @(posedge clk)
    begin
        if (!rx_choppy) begin
            m_axis_tready <= 1'b1;
        end
        else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 20)
                rx_stall = $urandom_range(1, 3);
            else if (rx_roll < 23)
                rx_stall = $urandom_range(15, 50);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all in steady stretches
    function automatic int pick_sender_gap();
        int roll;
        if (tx_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic send_item(input logic kind, input logic [7:0] id,
                             input logic [31:0] rec, input logic [31:0] stamp);
        int gap;
        gap = pick_sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, rec, id};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_report(input logic [7:0] id, input logic [31:0] rec,
                               input logic [31:0] stamp);
        send_item(KIND_REPORT, id, rec, stamp);
    endtask

    // Timer beats carry only the current time; scramble the rest to toggle its bits
    task automatic send_timer_check(input logic [31:0] now);
        send_item(KIND_TIMER, 8'($urandom), $urandom, now);
    endtask

    // Drop valid and hold until every predicted list beat has come out
    task automatic hold_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0) @(posedge clk);
    endtask

    // Drain, then let a silent timer scan finish before touching the register
    task automatic settle_idle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic set_expiry(input int value);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= 16'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_expiry = value;
    endtask

    // Overfill the table with fresh ids so the oldest gets pushed out, then
    // re-report a resident id (no drop), a long-gone id (drop), and age it out.
    task automatic run_fill_phase();
        logic [7:0] base;
        base = 8'($urandom);
        for (int i = 0; i < DEPTH + 6; i++) begin
            send_report(base + 8'(i), $urandom, clock_ms);
            clock_ms += $urandom_range(0, 3);
        end
        send_report(base + 8'd20, $urandom, clock_ms);
        send_report(base, $urandom, clock_ms);
        send_timer_check(clock_ms + 32'(cur_expiry / 2));
        clock_ms += 32'(cur_expiry) + 32'd100;
        send_timer_check(clock_ms);
    endtask

    // Reports over an id pool (so ids repeat) mixed with timers around the expiry
    task automatic run_mixed_phase(input int count);
        logic [7:0] pool_base;
        int         pool_size;
        int         roll;
        logic [31:0] stamp;
        pool_base = 8'($urandom);
        pool_size = $urandom_range(4, 100);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 3)
                hold_for_results();
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                if ($urandom_range(0, 9) == 0)
                    stamp = $urandom;
                else
                    stamp = clock_ms - $urandom_range(0, 50);
                send_report(pool_base + 8'($urandom_range(0, pool_size - 1)), $urandom, stamp);
                clock_ms += $urandom_range(0, cur_expiry / 8 + 2);
            end
            else if (roll < 72) begin
                send_timer_check($urandom);
            end
            else begin
                stamp = clock_ms + $urandom_range(0, 2 * cur_expiry + 2);
                send_timer_check(stamp);
                if ($urandom_range(0, 1) == 1)
                    clock_ms = stamp;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset expiry of 1000 ms
        send_report(8'h00, 32'h0000_0000, 32'd0);
        send_report(8'hFF, 32'hFFFF_FFFF, 32'd100);
        send_report(8'h07, 32'h1234_5678, 32'd200);
        // same id again: old entry leaves, new one goes to the tail
        send_report(8'h00, 32'hA5A5_A5A5, 32'd300);
        // nothing old enough: no beats
        send_timer_check(32'd500);
        // 0xFF is 1100 ms old and goes; 0x07 is exactly at the limit and stays
        send_timer_check(32'd1200);
        // stamps ahead of now wrap to a huge age: list empties, one invalid beat
        send_timer_check(32'd150);
        // timer on an empty list removes nothing
        send_timer_check(32'd0);
        // stamp at the top of the range, checked across the wrap to zero
        send_report(8'h80, 32'h8000_0000, 32'hFFFF_FFFF);
        send_timer_check(32'd999);
        send_timer_check(32'd1000);
        send_report(8'h55, 32'h5555_5555, 32'hAAAA_AAAA);
        send_report(8'hAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_timer_check(32'h5555_5555);
        clock_ms = 32'h5555_6000;

        // Random part: walk through register settings, extremes first
        set_expiry(0);
        run_mixed_phase(40);
        set_expiry(65535);
        rx_choppy = 1'b0;
        tx_steady = 1'b1;
        run_fill_phase();
        set_expiry($urandom_range(1, 65534));
        rx_choppy = 1'b1;
        tx_steady = 1'b0;
        run_mixed_phase(40);
        set_expiry(1000);
        run_fill_phase();
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0: set_expiry(0);
                1: set_expiry(65535);
                2: set_expiry($urandom_range(1, 64));
                default: set_expiry($urandom_range(0, 65535));
            endcase
            rx_choppy = ($urandom_range(0, 3) != 0);
            tx_steady = ($urandom_range(0, 3) == 0);
            run_mixed_phase($urandom_range(25, 50));
        end

        settle_idle();
        if (mismatch_count == 0 && beats_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: keyed_record_table_with_expiry_unit.f
hw/rtl/krte_pkg.sv
hw/rtl/krte_mem.sv
hw/rtl/krte_alu.sv
hw/rtl/keyed_record_table_with_expiry_unit.sv
sim/krte_list_checker.sv
sim/tb_top.sv
